/* rtl/core/orbs_pkg.sv */
// Shared types and constants for the orbit random subset builder.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package orbs_pkg;

    // Sizing limits of the set and of the orbit
    localparam int MAX_SIZE  = 64;
    localparam int MAX_ORBIT = 8;

    // Field and register widths
    localparam int VALUE_W     = 16;
    localparam int MAP_W       = 64;
    localparam int COUNT_W     = 7;
    localparam int STATUS_W    = 2;
    localparam int MODULUS_W   = 7;
    localparam int ORBIT_REG_W = 4;
    localparam int MULTS_W     = 64;
    localparam int MULT_W      = 8;
    localparam int LIMIT_W     = 9;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;

    // Derived widths
    localparam int POS_W  = $clog2(MAX_SIZE);
    localparam int MOD_W  = POS_W + 1;
    localparam int LEN_W  = $clog2(MAX_ORBIT + 1);
    localparam int SUM_W  = COUNT_W + 1;

    // Residue steps: bits consumed per cycle by the modular sequencers
    localparam int STEP_BITS  = 4;
    localparam int FR_STEPS   = VALUE_W / STEP_BITS;
    localparam int FR_STEP_W  = $clog2(FR_STEPS);
    localparam int BK_STEPS   = MULT_W / STEP_BITS;
    localparam int BK_STEP_W  = (BK_STEPS > 1) ? $clog2(BK_STEPS) : 1;

    // Popcount tree
    localparam int NUM_BYTES  = MAP_W / 8;
    localparam int BYTE_CNT_W = 4;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ORBIT_LEN   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_ORBIT_MULTS = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_TRY_LIMIT   = CFG_IDX_W'(4);

    // Register reset values
    localparam logic [MODULUS_W-1:0]   MODULUS_RST   = MODULUS_W'(64);
    localparam logic [COUNT_W-1:0]     TARGET_RST    = COUNT_W'(1);
    localparam logic [ORBIT_REG_W-1:0] ORBIT_LEN_RST = ORBIT_REG_W'(1);
    localparam logic [MULTS_W-1:0]     MULTS_RST     = MULTS_W'(1);
    localparam logic [LIMIT_W-1:0]     TRY_LIMIT_RST = LIMIT_W'(400);

    typedef enum logic [STATUS_W-1:0] {
        STAT_SEARCHING = 2'd0,
        STAT_FOUND     = 2'd1,
        STAT_GAVE_UP   = 2'd2
    } status_t;

    typedef enum logic {
        KIND_TRY         = 1'b0,
        KIND_ZERO_TARGET = 1'b1
    } kind_t;

    // Effective configuration, already saturated
    typedef struct packed {
        logic [MOD_W-1:0]   modulus;
        logic [COUNT_W-1:0] target;
        logic [LEN_W-1:0]   orbit_len;
        logic [MULTS_W-1:0] mults;
        logic [LIMIT_W-1:0] try_limit;
    } cfg_t;

    typedef struct packed {
        kind_t            kind;
        logic [POS_W-1:0] seed;
    } q_entry_t;

endpackage

`default_nettype wire

/* rtl/core/orbs_if.sv */
// Valid/ready channel interfaces for the sample input and the report output.
// Depends on orbs_pkg for the field widths.
`default_nettype none

interface orbs_in_if;
    logic                         valid;
    logic                         ready;
    logic [orbs_pkg::VALUE_W-1:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

interface orbs_out_if;
    logic                          valid;
    logic                          ready;
    logic [orbs_pkg::STATUS_W-1:0] search_status;
    logic [orbs_pkg::MAP_W-1:0]    selection_map;
    logic [orbs_pkg::COUNT_W-1:0]  selected_count;

    modport source (output valid, output search_status, output selection_map,
                    output selected_count, input ready);
    modport sink   (input valid, input search_status, input selection_map,
                    input selected_count, output ready);
endinterface

`default_nettype wire

/* rtl/core/orbs_front.sv */
// Front end: accepts a sample, classifies it and reduces it modulo the size.
// Depends on orbs_pkg and orbs_in_if; feeds orbs_queue.
`default_nettype none

module orbs_front (
    input  logic               clk,
    input  logic               rst_n,
    orbs_in_if.sink            sample,
    input  orbs_pkg::cfg_t     cfg,
    input  logic               q_full,
    output logic               q_push,
    output orbs_pkg::q_entry_t q_data
);

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_RUN,
        FR_PUSH
    } fr_state_t;

    fr_state_t                          state_reg, state_next;
    logic [orbs_pkg::VALUE_W-1:0]       value_reg, value_next;
    logic [orbs_pkg::POS_W-1:0]         acc_reg, acc_next;
    logic [orbs_pkg::FR_STEP_W-1:0]     step_reg, step_next;
    orbs_pkg::kind_t                    kind_reg, kind_next;

    always_comb
    begin : next_logic
        logic [orbs_pkg::MOD_W-1:0] trial;
        logic [orbs_pkg::POS_W-1:0] acc;
        trial      = '0;
        acc        = acc_reg;
        state_next = state_reg;
        value_next = value_reg;
        acc_next   = acc_reg;
        step_next  = step_reg;
        kind_next  = kind_reg;
        unique case (state_reg)
            FR_IDLE:
            begin
                if (sample.valid)
                begin
                    value_next = sample.random_value;
                    acc_next   = '0;
                    step_next  = '0;
                    kind_next  = (cfg.target == '0) ? orbs_pkg::KIND_ZERO_TARGET
                                                    : orbs_pkg::KIND_TRY;
                    state_next = FR_RUN;
                end
            end
            FR_RUN:
            begin
                // Restoring remainder, MSB first: acc = (2*acc + bit) mod v
                for (int k = 0; k < orbs_pkg::STEP_BITS; k++)
                begin
                    trial = {acc, value_reg[orbs_pkg::VALUE_W-1-k]};
                    if (trial >= cfg.modulus)
                    begin
                        trial = trial - cfg.modulus;
                    end
                    acc = trial[orbs_pkg::POS_W-1:0];
                end
                acc_next   = acc;
                value_next = value_reg << orbs_pkg::STEP_BITS;
                step_next  = step_reg + 1'b1;
                if (step_reg == orbs_pkg::FR_STEP_W'(orbs_pkg::FR_STEPS - 1))
                begin
                    state_next = FR_PUSH;
                end
            end
            FR_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            value_reg <= value_next;
            acc_reg   <= acc_next;
            step_reg  <= step_next;
            kind_reg  <= kind_next;
        end
    end

    assign sample.ready = (state_reg == FR_IDLE);
    assign q_push       = (state_reg == FR_PUSH) && !q_full;
    assign q_data       = '{kind: kind_reg, seed: acc_reg};

endmodule

`default_nettype wire

/* rtl/core/orbs_queue.sv */
// Short queue of reduced samples between the front and back ends.
// Depends on orbs_pkg for the entry type and depth.
`default_nettype none

module orbs_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  orbs_pkg::q_entry_t push_data,
    output logic               full,
    input  logic               pop,
    output orbs_pkg::q_entry_t pop_data,
    output logic               empty
);

    orbs_pkg::q_entry_t              entries_reg [orbs_pkg::QUEUE_DEPTH];
    logic [orbs_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [orbs_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [orbs_pkg::QCNT_W-1:0]     count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == orbs_pkg::QPTR_W'(orbs_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == orbs_pkg::QPTR_W'(orbs_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full     = (count_reg == orbs_pkg::QCNT_W'(orbs_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entries_reg[rd_ptr_reg];

endmodule

`default_nettype wire

/* rtl/core/orbs_back.sv */
// Back end: expands the orbit of a seed into the member set, counts members,
// decides the search status and holds the report register.
// Depends on orbs_pkg and orbs_out_if; drained from orbs_queue.
`default_nettype none

module orbs_back (
    input  logic               clk,
    input  logic               rst_n,
    input  orbs_pkg::cfg_t     cfg,
    input  logic               q_empty,
    input  orbs_pkg::q_entry_t q_data,
    output logic               q_pop,
    orbs_out_if.source         report
);

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_MERGE,
        BK_CNT_BYTES,
        BK_CNT_SUM,
        BK_DECIDE
    } bk_state_t;

    typedef enum logic {
        MODE_TRY,
        MODE_REPORT
    } bk_mode_t;

    bk_state_t                            state_reg, state_next;
    bk_mode_t                             mode_reg, mode_next;
    orbs_pkg::status_t                    status_reg, status_next;
    logic [orbs_pkg::MAP_W-1:0]           map_reg, map_next;
    logic [orbs_pkg::COUNT_W-1:0]         raw_reg, raw_next;
    logic [orbs_pkg::LIMIT_W-1:0]         tries_reg, tries_next;
    logic [orbs_pkg::POS_W-1:0]           seed_reg, seed_next;
    logic [orbs_pkg::POS_W-1:0]           lane_acc_reg [orbs_pkg::MAX_ORBIT];
    logic [orbs_pkg::POS_W-1:0]           lane_acc_next [orbs_pkg::MAX_ORBIT];
    logic [orbs_pkg::MULT_W-1:0]          lane_mult_reg [orbs_pkg::MAX_ORBIT];
    logic [orbs_pkg::MULT_W-1:0]          lane_mult_next [orbs_pkg::MAX_ORBIT];
    logic [orbs_pkg::BK_STEP_W-1:0]       step_reg, step_next;
    logic [orbs_pkg::SUM_W-1:0]           sum_reg, sum_next;
    logic [orbs_pkg::BYTE_CNT_W-1:0]      byte_cnt_reg [orbs_pkg::NUM_BYTES];
    logic [orbs_pkg::BYTE_CNT_W-1:0]      byte_cnt_next [orbs_pkg::NUM_BYTES];
    logic [orbs_pkg::COUNT_W-1:0]         pc_reg, pc_next;
    logic                                 out_valid_reg, out_valid_next;
    orbs_pkg::status_t                    out_status_reg, out_status_next;
    logic [orbs_pkg::MAP_W-1:0]           out_map_reg, out_map_next;
    logic [orbs_pkg::COUNT_W-1:0]         out_count_reg, out_count_next;

    function automatic logic [orbs_pkg::BYTE_CNT_W-1:0] popcount8(input logic [7:0] b);
        logic [orbs_pkg::BYTE_CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + orbs_pkg::BYTE_CNT_W'(b[i]);
        end
        return n;
    endfunction

    always_comb
    begin : next_logic
        logic [orbs_pkg::POS_W+1:0]   trial;
        logic [orbs_pkg::POS_W-1:0]   acc;
        logic [orbs_pkg::MOD_W:0]     mod2;
        logic [orbs_pkg::SUM_W-1:0]   settled;
        logic                         over;
        orbs_pkg::status_t            st;
        logic [orbs_pkg::COUNT_W-1:0] total;

        trial   = '0;
        acc     = '0;
        mod2    = {cfg.modulus, 1'b0};
        settled = '0;
        over    = 1'b0;
        st      = orbs_pkg::STAT_SEARCHING;
        total   = '0;

        state_next      = state_reg;
        mode_next       = mode_reg;
        status_next     = status_reg;
        map_next        = map_reg;
        raw_next        = raw_reg;
        tries_next      = tries_reg;
        seed_next       = seed_reg;
        lane_acc_next   = lane_acc_reg;
        lane_mult_next  = lane_mult_reg;
        step_next       = step_reg;
        sum_next        = sum_reg;
        byte_cnt_next   = byte_cnt_reg;
        pc_next         = pc_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_map_next    = out_map_reg;
        out_count_next  = out_count_reg;
        q_pop           = 1'b0;

        // Drop the report once it has been transferred
        if (out_valid_reg && report.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop     = 1'b1;
                    seed_next = q_data.seed;
                    step_next = '0;
                    for (int j = 0; j < orbs_pkg::MAX_ORBIT; j++)
                    begin
                        lane_acc_next[j]  = '0;
                        lane_mult_next[j] = cfg.mults[orbs_pkg::MULT_W*j +: orbs_pkg::MULT_W];
                    end
                    if (q_data.kind == orbs_pkg::KIND_ZERO_TARGET)
                    begin
                        // Found at once with an empty set
                        map_next    = '0;
                        raw_next    = '0;
                        tries_next  = '0;
                        mode_next   = MODE_REPORT;
                        status_next = orbs_pkg::STAT_FOUND;
                        state_next  = BK_CNT_BYTES;
                    end
                    else if (tries_reg >= cfg.try_limit)
                    begin
                        mode_next   = MODE_REPORT;
                        status_next = orbs_pkg::STAT_GAVE_UP;
                        state_next  = BK_CNT_BYTES;
                    end
                    else
                    begin
                        tries_next = tries_reg + 1'b1;
                        mode_next  = MODE_TRY;
                        state_next = BK_MUL;
                    end
                end
            end
            BK_MUL:
            begin
                // Per lane, MSB first: acc = (2*acc + bit*seed) mod v
                for (int j = 0; j < orbs_pkg::MAX_ORBIT; j++)
                begin
                    acc = lane_acc_reg[j];
                    for (int k = 0; k < orbs_pkg::STEP_BITS; k++)
                    begin
                        trial = {1'b0, acc, 1'b0}
                              + (lane_mult_reg[j][orbs_pkg::MULT_W-1-k]
                                 ? {2'b00, seed_reg} : '0);
                        if (trial >= mod2)
                        begin
                            trial = trial - mod2;
                        end
                        else if (trial >= {1'b0, cfg.modulus})
                        begin
                            trial = trial - {1'b0, cfg.modulus};
                        end
                        acc = trial[orbs_pkg::POS_W-1:0];
                    end
                    lane_acc_next[j]  = acc;
                    lane_mult_next[j] = lane_mult_reg[j] << orbs_pkg::STEP_BITS;
                end
                step_next = step_reg + 1'b1;
                if (step_reg == orbs_pkg::BK_STEP_W'(orbs_pkg::BK_STEPS - 1))
                begin
                    state_next = BK_MERGE;
                end
            end
            BK_MERGE:
            begin
                for (int j = 0; j < orbs_pkg::MAX_ORBIT; j++)
                begin
                    if (orbs_pkg::LEN_W'(j) < cfg.orbit_len)
                    begin
                        map_next[lane_acc_reg[j]] = 1'b1;
                    end
                end
                sum_next   = orbs_pkg::SUM_W'(raw_reg) + orbs_pkg::SUM_W'(cfg.orbit_len);
                state_next = BK_CNT_BYTES;
            end
            BK_CNT_BYTES:
            begin
                for (int b = 0; b < orbs_pkg::NUM_BYTES; b++)
                begin
                    byte_cnt_next[b] = popcount8(map_reg[8*b +: 8]);
                end
                state_next = BK_CNT_SUM;
            end
            BK_CNT_SUM:
            begin
                for (int b = 0; b < orbs_pkg::NUM_BYTES; b++)
                begin
                    total = total + orbs_pkg::COUNT_W'(byte_cnt_reg[b]);
                end
                pc_next    = total;
                state_next = BK_DECIDE;
            end
            BK_DECIDE:
            begin
                // Hold until the report register is free
                if (!out_valid_reg || report.ready)
                begin
                    out_map_next   = map_reg;
                    out_count_next = pc_reg;
                    if (mode_reg == MODE_TRY)
                    begin
                        // Raw count reached the target: replace it by the distinct count
                        settled = (sum_reg >= orbs_pkg::SUM_W'(cfg.target))
                                  ? orbs_pkg::SUM_W'(pc_reg) : sum_reg;
                        over    = settled > orbs_pkg::SUM_W'(cfg.target);
                        if (over)
                        begin
                            map_next       = '0;
                            raw_next       = '0;
                            out_map_next   = '0;
                            out_count_next = '0;
                        end
                        else
                        begin
                            raw_next = settled[orbs_pkg::COUNT_W-1:0];
                            if (settled == orbs_pkg::SUM_W'(cfg.target))
                            begin
                                st = orbs_pkg::STAT_FOUND;
                            end
                        end
                    end
                    else
                    begin
                        st = status_reg;
                    end
                    if (st != orbs_pkg::STAT_SEARCHING)
                    begin
                        map_next   = '0;
                        raw_next   = '0;
                        tries_next = '0;
                    end
                    out_status_next = st;
                    out_valid_next  = 1'b1;
                    state_next      = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            map_reg       <= '0;
            raw_reg       <= '0;
            tries_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            status_reg     <= status_next;
            map_reg        <= map_next;
            raw_reg        <= raw_next;
            tries_reg      <= tries_next;
            seed_reg       <= seed_next;
            lane_acc_reg   <= lane_acc_next;
            lane_mult_reg  <= lane_mult_next;
            step_reg       <= step_next;
            sum_reg        <= sum_next;
            byte_cnt_reg   <= byte_cnt_next;
            pc_reg         <= pc_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_map_reg    <= out_map_next;
            out_count_reg  <= out_count_next;
        end
    end

    assign report.valid          = out_valid_reg;
    assign report.search_status  = out_status_reg;
    assign report.selection_map  = out_map_reg;
    assign report.selected_count = out_count_reg;

endmodule

`default_nettype wire

/* rtl/core/orbit_random_subset_builder_unit.sv */
// A sample transfer becomes a report through the front end (reduce, push), the queue and the
// back end; a try that finds the budget spent or the target zero skips the multiply and merge.
// The back end takes one try at a time (pop, lane modular multiply, merge, byte popcount, sum
// of the byte counts, decide); the front end runs ahead through a 2-entry queue.
// Reset: configuration to its defaults, member set and counters cleared,
// queue emptied; the front end is idle and ready for a sample out of reset.
`default_nettype none

module orbit_random_subset_builder_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    orbs_in_if.sink                             sample,
    orbs_out_if.source                          report,
    input  logic                                cfg_write,
    input  logic [orbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [orbs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [orbs_pkg::MODULUS_W-1:0]   modulus_reg;
    logic [orbs_pkg::COUNT_W-1:0]     target_reg;
    logic [orbs_pkg::ORBIT_REG_W-1:0] orbit_len_reg;
    logic [orbs_pkg::MULTS_W-1:0]     mults_reg;
    logic [orbs_pkg::LIMIT_W-1:0]     try_limit_reg;

    orbs_pkg::cfg_t     cfg;
    logic               q_push;
    orbs_pkg::q_entry_t q_push_data;
    logic               q_full;
    logic               q_pop;
    orbs_pkg::q_entry_t q_pop_data;
    logic               q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= orbs_pkg::MODULUS_RST;
            target_reg    <= orbs_pkg::TARGET_RST;
            orbit_len_reg <= orbs_pkg::ORBIT_LEN_RST;
            mults_reg     <= orbs_pkg::MULTS_RST;
            try_limit_reg <= orbs_pkg::TRY_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                orbs_pkg::CFG_MODULUS:     modulus_reg   <= cfg_data[orbs_pkg::MODULUS_W-1:0];
                orbs_pkg::CFG_TARGET:      target_reg    <= cfg_data[orbs_pkg::COUNT_W-1:0];
                orbs_pkg::CFG_ORBIT_LEN:   orbit_len_reg <= cfg_data[orbs_pkg::ORBIT_REG_W-1:0];
                orbs_pkg::CFG_ORBIT_MULTS: mults_reg     <= cfg_data[orbs_pkg::MULTS_W-1:0];
                orbs_pkg::CFG_TRY_LIMIT:   try_limit_reg <= cfg_data[orbs_pkg::LIMIT_W-1:0];
                default:                   ;
            endcase
        end
    end

    // Saturate modulus to 1..MAX_SIZE and orbit length to MAX_ORBIT
    always_comb
    begin
        if (modulus_reg == '0)
        begin
            cfg.modulus = orbs_pkg::MOD_W'(1);
        end
        else if (modulus_reg > orbs_pkg::MODULUS_W'(orbs_pkg::MAX_SIZE))
        begin
            cfg.modulus = orbs_pkg::MOD_W'(orbs_pkg::MAX_SIZE);
        end
        else
        begin
            cfg.modulus = orbs_pkg::MOD_W'(modulus_reg);
        end
        if (orbit_len_reg > orbs_pkg::ORBIT_REG_W'(orbs_pkg::MAX_ORBIT))
        begin
            cfg.orbit_len = orbs_pkg::LEN_W'(orbs_pkg::MAX_ORBIT);
        end
        else
        begin
            cfg.orbit_len = orbs_pkg::LEN_W'(orbit_len_reg);
        end
        cfg.target    = target_reg;
        cfg.mults     = mults_reg;
        cfg.try_limit = try_limit_reg;
    end

    orbs_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .cfg    (cfg),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_push_data)
    );

    orbs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    orbs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_empty (q_empty),
        .q_data  (q_pop_data),
        .q_pop   (q_pop),
        .report  (report)
    );

endmodule

`default_nettype wire

/* rtl/core/orbs_checker.sv */
// Port-level checks of the subset builder's reports, bound to the top level.
// Depends on orbs_pkg and orbit_random_subset_builder_unit.
`default_nettype none

module orbs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cfg_write,
    input logic [orbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [orbs_pkg::CFG_DATA_W-1:0] cfg_data,
    input logic                            report_valid,
    input logic                            report_ready,
    input logic [orbs_pkg::STATUS_W-1:0]   search_status,
    input logic [orbs_pkg::MAP_W-1:0]      selection_map,
    input logic [orbs_pkg::COUNT_W-1:0]    selected_count
);

    logic [orbs_pkg::COUNT_W-1:0] target_shadow_reg;

    // Track the target as written on the configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_shadow_reg <= orbs_pkg::TARGET_RST;
        end
        else if (cfg_write && (cfg_index == orbs_pkg::CFG_TARGET))
        begin
            target_shadow_reg <= cfg_data[orbs_pkg::COUNT_W-1:0];
        end
    end

    a_report_hold: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !report_ready |=> report_valid)
        else $error("report dropped before transfer");

    a_count_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid |-> selected_count == orbs_pkg::COUNT_W'($countones(selection_map)))
        else $error("selected_count differs from members in selection_map");

    a_found_hits_target: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && (search_status == orbs_pkg::STAT_FOUND)
        |-> selected_count == target_shadow_reg)
        else $error("found report without target member count");

    a_searching_below_target: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && (search_status == orbs_pkg::STAT_SEARCHING)
        |-> selected_count < target_shadow_reg)
        else $error("searching report at or above target count");

endmodule

bind orbit_random_subset_builder_unit orbs_checker u_orbs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .report_valid   (report.valid),
    .report_ready   (report.ready),
    .search_status  (report.search_status),
    .selection_map  (report.selection_map),
    .selected_count (report.selected_count)
);

`default_nettype wire

/* verif/orbit_random_subset_builder_unit_test.sv */
// Self-checking testbench for orbit_random_subset_builder_unit: directed table, then random
// search phases under several register settings, checked against an in-bench search predictor.
// Depends on orbs_pkg and the orbs_in_if / orbs_out_if channel interfaces.
`timescale 1ns / 100ps

module orbit_random_subset_builder_unit_test;
    import orbs_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 1_000_000;
    localparam int unsigned PHASES          = 16;
    localparam int unsigned TRIES_PER_PHASE = 100;
    localparam int unsigned DRAIN_CYCLES    = 36;
    localparam int unsigned HOLD_CYCLES     = 300;
    localparam int unsigned PRINT_CAP       = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(7);

    typedef struct packed {
        status_t            st;
        logic [MAP_W-1:0]   map;
        logic [COUNT_W-1:0] cnt;
    } report_t;

    typedef struct packed {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [VALUE_W-1:0]    value;
        bit                    known;
        report_t               rep;
    } row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    orbs_in_if  sample_ch ();
    orbs_out_if report_ch ();

    orbit_random_subset_builder_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .report    (report_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register mirror and search state of the predictor
    logic [MODULUS_W-1:0]   cfg_modulus   = MODULUS_RST;
    logic [COUNT_W-1:0]     cfg_target    = TARGET_RST;
    logic [ORBIT_REG_W-1:0] cfg_orbit_len = ORBIT_LEN_RST;
    logic [MULTS_W-1:0]     cfg_mults     = MULTS_RST;
    logic [LIMIT_W-1:0]     cfg_try_limit = TRY_LIMIT_RST;
    logic [MAP_W-1:0]       members       = '0;
    int unsigned            raw_count     = 0;
    int unsigned            tries_used    = 0;

    report_t     pending_reports[$];
    row_t        directed_rows[$];
    int unsigned mismatches    = 0;
    int unsigned reports_taken = 0;
    int unsigned cycle_count   = 0;
    int unsigned hold_left     = 0;
    int unsigned pause_left    = 0;
    bit          bursty        = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic report_t advance_search(input logic [VALUE_W-1:0] value);
        int unsigned size;
        int unsigned len;
        int unsigned seed;
        int unsigned total;
        report_t     rep;
        size = (cfg_modulus == 0) ? 1 : ((cfg_modulus > MAX_SIZE) ? MAX_SIZE : cfg_modulus);
        len  = (cfg_orbit_len > MAX_ORBIT) ? MAX_ORBIT : cfg_orbit_len;
        rep.st = STAT_SEARCHING;
        if (cfg_target == 0)
        begin
            members = '0;
            rep.st  = STAT_FOUND;
        end
        else if (tries_used >= cfg_try_limit)
        begin
            rep.st = STAT_GAVE_UP;
        end
        else
        begin
            seed = value % size;
            tries_used++;
            for (int j = 0; j < len; j++)
                members[(seed * cfg_mults[8*j +: 8]) % size] = 1'b1;
            total = raw_count + len;
            if (total >= cfg_target)
                total = $countones(members);
            if (total > cfg_target)
            begin
                members = '0;
                total   = 0;
            end
            raw_count = total;
            if (total == cfg_target)
                rep.st = STAT_FOUND;
        end
        rep.map = members;
        rep.cnt = COUNT_W'($countones(members));
        // a finished search starts over on the next try
        if (rep.st != STAT_SEARCHING)
        begin
            members    = '0;
            raw_count  = 0;
            tries_used = 0;
        end
        return rep;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!bursty)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch on %s at cycle %0d: got %0h, want %0h",
                     what, cycle_count, got, want);
    endtask

    // Drop valid and wait for every outstanding report.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    // Write one register once the block is idle; the enable stays high for a following write.
    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] data;
        data = {$urandom, $urandom};
        settle();
        case (idx)
            CFG_MODULUS:
            begin
                data[MODULUS_W-1:0] = value[MODULUS_W-1:0];
                cfg_modulus         = value[MODULUS_W-1:0];
            end
            CFG_TARGET:
            begin
                data[COUNT_W-1:0] = value[COUNT_W-1:0];
                cfg_target        = value[COUNT_W-1:0];
            end
            CFG_ORBIT_LEN:
            begin
                data[ORBIT_REG_W-1:0] = value[ORBIT_REG_W-1:0];
                cfg_orbit_len         = value[ORBIT_REG_W-1:0];
            end
            CFG_ORBIT_MULTS:
            begin
                data      = value;
                cfg_mults = value;
            end
            CFG_TRY_LIMIT:
            begin
                data[LIMIT_W-1:0] = value[LIMIT_W-1:0];
                cfg_try_limit     = value[LIMIT_W-1:0];
            end
            default:
                data = value;
        endcase
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic send_try(input logic [VALUE_W-1:0] value, input bit known,
                            input report_t known_rep);
        int unsigned gap;
        report_t     predicted;
        gap = pick_gap();
        cfg_write <= 1'b0;
        if (gap != 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.random_value <= value;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        predicted = advance_search(value);
        pending_reports.push_back(known ? known_rep : predicted);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        directed_rows.push_back(r);
    endtask

    task automatic add_try(input logic [VALUE_W-1:0] value);
        row_t r;
        r       = '0;
        r.value = value;
        directed_rows.push_back(r);
    endtask

    task automatic add_known(input logic [VALUE_W-1:0] value, input status_t st,
                             input logic [MAP_W-1:0] map, input logic [COUNT_W-1:0] cnt);
        row_t r;
        r         = '0;
        r.value   = value;
        r.known   = 1'b1;
        r.rep.st  = st;
        r.rep.map = map;
        r.rep.cnt = cnt;
        directed_rows.push_back(r);
    endtask

    // Receiver: check each report transfer, then pick ready for the next cycle.
    always @(posedge clk)
    begin : receiver
        report_t oldest;
        if (rst_n && report_ch.valid && report_ch.ready)
        begin
            reports_taken++;
            if (pending_reports.size() == 0)
            begin
                report_mismatch("report with nothing pending", report_ch.selection_map, '0);
            end
            else
            begin
                oldest = pending_reports.pop_front();
                if (report_ch.search_status !== oldest.st)
                    report_mismatch("search_status", report_ch.search_status, oldest.st);
                if (report_ch.selection_map !== oldest.map)
                    report_mismatch("selection_map", report_ch.selection_map, oldest.map);
                if (report_ch.selected_count !== oldest.cnt)
                    report_mismatch("selected_count", report_ch.selected_count, oldest.cnt);
            end
            // long hold-off so the queue fills and the input stalls
            if (reports_taken == 200 || reports_taken == 1000)
                hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            report_ch.ready <= 1'b0;
        end
        else if (pause_left != 0)
        begin
            pause_left--;
            report_ch.ready <= 1'b0;
        end
        else
        begin
            report_ch.ready <= 1'b1;
            pause_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout at cycle %0d with %0d reports pending",
                     cycle_count, pending_reports.size());
            $display("FAIL orbit_random_subset_builder_unit");
            $finish;
        end
    end

    initial
    begin
        logic [VALUE_W-1:0]    value;
        logic [CFG_DATA_W-1:0] set_mod;
        logic [CFG_DATA_W-1:0] set_target;
        logic [CFG_DATA_W-1:0] set_len;
        logic [CFG_DATA_W-1:0] set_limit;
        int unsigned           sel;

        rst_n                  = 1'b0;
        cfg_write              = 1'b0;
        cfg_index              = CFG_MODULUS;
        cfg_data               = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.random_value = '0;
        report_ch.ready        = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: one-member target, identity multiplier, full-size modulus
        add_known(16'h0000, STAT_FOUND, 64'h1, 7'd1);
        add_known(16'hFFFF, STAT_FOUND, 64'h8000_0000_0000_0000, 7'd1);
        add_known(16'h0041, STAT_FOUND, 64'h2, 7'd1);
        // zero target: found at once with an empty set
        add_cfg(CFG_TARGET, 64'd0);
        add_known(16'h1234, STAT_FOUND, 64'h0, 7'd0);
        // zero try budget: gives up on every try
        add_cfg(CFG_TARGET, 64'd127);
        add_cfg(CFG_TRY_LIMIT, 64'd0);
        add_known(16'h5555, STAT_GAVE_UP, 64'h0, 7'd0);
        add_known(16'hAAAA, STAT_GAVE_UP, 64'h0, 7'd0);
        // zero modulus acts as one; budget of two runs out on the third try
        add_cfg(CFG_TRY_LIMIT, 64'd2);
        add_cfg(CFG_MODULUS, 64'd0);
        add_known(16'hBEEF, STAT_SEARCHING, 64'h1, 7'd1);
        add_known(16'h0000, STAT_SEARCHING, 64'h1, 7'd1);
        add_known(16'h0007, STAT_GAVE_UP, 64'h1, 7'd1);
        // oversized modulus and orbit length saturate
        add_cfg(CFG_MODULUS, 64'd127);
        add_cfg(CFG_ORBIT_LEN, 64'd15);
        add_cfg(CFG_ORBIT_MULTS, 64'h0102_0408_1020_4080);
        add_cfg(CFG_TARGET, 64'd64);
        add_cfg(CFG_TRY_LIMIT, 64'd511);
        add_try(16'h0001);
        add_try(16'h0003);
        add_try(16'hFFFF);
        // empty orbit adds nothing
        add_cfg(CFG_ORBIT_LEN, 64'd0);
        add_try(16'h0005);
        // overshoot of the target clears the set
        add_cfg(CFG_TARGET, 64'd1);
        add_cfg(CFG_ORBIT_LEN, 64'd2);
        add_cfg(CFG_ORBIT_MULTS, 64'h0201);
        add_cfg(CFG_MODULUS, 64'd64);
        add_known(16'h0001, STAT_SEARCHING, 64'h0, 7'd0);
        // all-ones and all-zeros multipliers collapse the orbit to one position
        add_cfg(CFG_ORBIT_MULTS, 64'hFFFF_FFFF_FFFF_FFFF);
        add_cfg(CFG_ORBIT_LEN, 64'd8);
        add_known(16'h0001, STAT_FOUND, 64'h8000_0000_0000_0000, 7'd1);
        add_cfg(CFG_ORBIT_MULTS, 64'd0);
        add_known(16'h1234, STAT_FOUND, 64'h1, 7'd1);
        // target above what the modulus can hold never gets found
        add_cfg(CFG_MODULUS, 64'd2);
        add_cfg(CFG_TARGET, 64'd3);
        add_cfg(CFG_TRY_LIMIT, 64'd3);
        add_cfg(CFG_ORBIT_MULTS, 64'h0201);
        add_cfg(CFG_ORBIT_LEN, 64'd2);
        add_known(16'h0001, STAT_SEARCHING, 64'h3, 7'd2);
        add_known(16'h0000, STAT_SEARCHING, 64'h3, 7'd2);
        add_known(16'h0001, STAT_SEARCHING, 64'h3, 7'd2);
        add_known(16'h0001, STAT_GAVE_UP, 64'h3, 7'd2);

        bursty = 1'b1;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                cfg_put(directed_rows[i].idx, directed_rows[i].data);
            else
                send_try(directed_rows[i].value, directed_rows[i].known,
                         directed_rows[i].rep);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
            begin
                set_mod    = 64;
                set_target = 64;
                set_len    = 8;
                set_limit  = 511;
            end
            else if (p == 1)
            begin
                set_mod    = 1;
                set_target = 1;
                set_len    = 1;
                set_limit  = 1;
            end
            else
            begin
                sel     = $urandom_range(0, 19);
                set_mod = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(65, 127)
                                                      : $urandom_range(1, 64);
                sel     = $urandom_range(0, 19);
                set_len = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(9, 15)
                                                      : $urandom_range(1, 8);
                sel        = $urandom_range(0, 19);
                set_target = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(65, 127)
                           : (sel == 2) ? $urandom_range(1, 64) : $urandom_range(1, 8);
                sel        = $urandom_range(0, 19);
                set_limit  = (sel == 0) ? 0 : (sel == 1) ? $urandom_range(1, 4)
                                                         : $urandom_range(5, 511);
            end
            cfg_put(CFG_MODULUS, set_mod);
            cfg_put(CFG_TARGET, set_target);
            cfg_put(CFG_ORBIT_LEN, set_len);
            cfg_put(CFG_ORBIT_MULTS, {$urandom, $urandom});
            cfg_put(CFG_TRY_LIMIT, set_limit);
            cfg_put(CFG_UNUSED, {$urandom, $urandom});
            // every fourth phase runs with both sides at full rate
            bursty = (p % 4) != 0;
            for (int i = 0; i < TRIES_PER_PHASE; i++)
            begin
                value = ($urandom_range(0, 7) == 0) ? VALUE_W'($urandom_range(0, 127))
                                                    : VALUE_W'($urandom_range(0, 65535));
                send_try(value, 1'b0, '0);
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("PASS orbit_random_subset_builder_unit");
        else
            $display("FAIL orbit_random_subset_builder_unit");
        $finish;
    end

endmodule
